FILE: design/bpsc_pkg.sv
// Shared types, codes and the base decode function of the substitution counter.
package bpsc_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 32;
  localparam int OUT_WIDTH           = 32;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_COLUMN = 2'd0;
  localparam opcode_t OP_READ   = 2'd1;
  localparam opcode_t OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    CLASS_NONE,
    CLASS_MATCH,
    CLASS_TRANSITION,
    CLASS_TRANSVERSION
  } class_t;

  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_C      = 8'h43;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_T      = 8'h54;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [2:0] CODE_A       = 3'd0;
  localparam logic [2:0] CODE_C       = 3'd1;
  localparam logic [2:0] CODE_G       = 3'd2;
  localparam logic [2:0] CODE_T       = 3'd3;
  localparam logic [2:0] CODE_INVALID = 3'd4;

  typedef struct packed {
    logic       valid;
    class_t     cls;
    logic [3:0] idx;
  } col_info_t;

  typedef struct packed {
    class_t                 cls;
    logic [OUT_WIDTH-1:0]   match_total;
    logic [OUT_WIDTH-1:0]   mismatch_total;
    logic [OUT_WIDTH-1:0]   transition_total;
    logic [OUT_WIDTH-1:0]   transversion_total;
    logic [OUT_WIDTH-1:0]   bin_value;
  } result_t;

  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [7:0] up;
    begin
      up = (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) ? ch - CASE_OFFSET : ch;
      case (up)
        CHAR_A:  return CODE_A;
        CHAR_C:  return CODE_C;
        CHAR_G:  return CODE_G;
        CHAR_T:  return CODE_T;
        default: return CODE_INVALID;
      endcase
    end
  endfunction

endpackage

FILE: design/bpsc_column_decode.sv
// Column decoder: folds case, checks both bases and classes the pair.
module bpsc_column_decode (
  input  bpsc_pkg::opcode_t   opcode,
  input  logic [7:0]          base_a,
  input  logic [7:0]          base_b,
  output bpsc_pkg::col_info_t info
);

  logic [2:0] code_a;
  logic [2:0] code_b;

  assign code_a = bpsc_pkg::base_code(base_a);
  assign code_b = bpsc_pkg::base_code(base_b);

  always_comb begin
    info.valid = (opcode == bpsc_pkg::OP_COLUMN) && !code_a[2] && !code_b[2];
    info.idx   = {code_a[1:0], code_b[1:0]};
    if (!info.valid) begin
      info.cls = bpsc_pkg::CLASS_NONE;
    end else if (code_a == code_b) begin
      info.cls = bpsc_pkg::CLASS_MATCH;
    end else if ((code_a[1:0] ^ code_b[1:0]) == 2'b10) begin
      info.cls = bpsc_pkg::CLASS_TRANSITION;
    end else begin
      info.cls = bpsc_pkg::CLASS_TRANSVERSION;
    end
  end

endmodule

FILE: design/bpsc_count_bank.sv
// Counter bank: the four saturating totals and the 16-bin pair histogram.
module bpsc_count_bank #(
  parameter int COUNT_WIDTH = bpsc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  bpsc_pkg::opcode_t   opcode,
  input  bpsc_pkg::col_info_t info,
  input  logic [3:0]          bin_index,
  output bpsc_pkg::result_t   result
);

  localparam int BINS = 16;

  logic [COUNT_WIDTH-1:0] match_sum;
  logic [COUNT_WIDTH-1:0] mismatch_sum;
  logic [COUNT_WIDTH-1:0] transition_sum;
  logic [COUNT_WIDTH-1:0] transversion_sum;
  logic [COUNT_WIDTH-1:0] hist [BINS];

  logic [COUNT_WIDTH-1:0] match_sum_next;
  logic [COUNT_WIDTH-1:0] mismatch_sum_next;
  logic [COUNT_WIDTH-1:0] transition_sum_next;
  logic [COUNT_WIDTH-1:0] transversion_sum_next;
  logic [COUNT_WIDTH-1:0] hist_next [BINS];
  logic [COUNT_WIDTH-1:0] bin_inc;
  logic [COUNT_WIDTH-1:0] bin_out;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [bpsc_pkg::OUT_WIDTH-1:0] low_word(
    input logic [COUNT_WIDTH-1:0] v
  );
    logic [63:0] ext;
    begin
      ext = 64'(v);
      return ext[bpsc_pkg::OUT_WIDTH-1:0];
    end
  endfunction

  assign bin_inc = sat_inc(hist[info.idx]);

  always_comb begin
    match_sum_next        = match_sum;
    mismatch_sum_next     = mismatch_sum;
    transition_sum_next   = transition_sum;
    transversion_sum_next = transversion_sum;
    for (int i = 0; i < BINS; i++) begin
      hist_next[i] = hist[i];
    end
    bin_out = '0;
    case (opcode)
      bpsc_pkg::OP_COLUMN: begin
        if (info.valid) begin
          case (info.cls)
            bpsc_pkg::CLASS_MATCH: begin
              match_sum_next = sat_inc(match_sum);
            end
            bpsc_pkg::CLASS_TRANSITION: begin
              transition_sum_next = sat_inc(transition_sum);
              mismatch_sum_next   = sat_inc(mismatch_sum);
            end
            bpsc_pkg::CLASS_TRANSVERSION: begin
              transversion_sum_next = sat_inc(transversion_sum);
              mismatch_sum_next     = sat_inc(mismatch_sum);
            end
            default: begin
            end
          endcase
          hist_next[info.idx] = bin_inc;
          bin_out             = bin_inc;
        end
      end
      bpsc_pkg::OP_READ: begin
        bin_out = hist[bin_index];
      end
      bpsc_pkg::OP_CLEAR: begin
        match_sum_next        = '0;
        mismatch_sum_next     = '0;
        transition_sum_next   = '0;
        transversion_sum_next = '0;
        for (int i = 0; i < BINS; i++) begin
          hist_next[i] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_sum        <= '0;
      mismatch_sum     <= '0;
      transition_sum   <= '0;
      transversion_sum <= '0;
      for (int i = 0; i < BINS; i++) begin
        hist[i] <= '0;
      end
    end else if (advance) begin
      match_sum        <= match_sum_next;
      mismatch_sum     <= mismatch_sum_next;
      transition_sum   <= transition_sum_next;
      transversion_sum <= transversion_sum_next;
      for (int i = 0; i < BINS; i++) begin
        hist[i] <= hist_next[i];
      end
    end
  end

  always_comb begin
    result.cls                = info.cls;
    result.match_total        = low_word(match_sum_next);
    result.mismatch_total     = low_word(mismatch_sum_next);
    result.transition_total   = low_word(transition_sum_next);
    result.transversion_total = low_word(transversion_sum_next);
    result.bin_value          = low_word(bin_out);
  end

endmodule

FILE: design/base_pair_substitution_counter_unit.sv
// Top level of the substitution counter: input register, counter bank, result register.
// Each beat on the input stream is one aligned column, a histogram read or a clear, and
// gives exactly one result beat. A beat passes an input register, decode and counter update,
// and a result register; it leaves the input register once the result register is free or
// being read, and one beat can be taken every cycle while m_tready is held high, since the counter
// registers are read, modified and written as a beat advances. Results report the low 32
// bits of COUNT_WIDTH-bit saturating counters, and all counts are zero after reset.
module base_pair_substitution_counter_unit #(
  parameter int COUNT_WIDTH = bpsc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // base_a[7:0], base_b[15:8], bin_index[19:16], zero pad
  input  logic [1:0]   s_tuser,   // opcode[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // match, mismatch, transition, transversion, bin_value
  output logic [1:0]   m_tuser    // column_class[1:0]
);

  logic                in_valid;
  bpsc_pkg::opcode_t   in_opcode;
  logic [7:0]          in_base_a;
  logic [7:0]          in_base_b;
  logic [3:0]          in_bin_index;
  logic                out_valid;
  bpsc_pkg::result_t   out_result;
  logic                advance;
  bpsc_pkg::col_info_t info;
  bpsc_pkg::result_t   result;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_opcode    <= s_tuser;
      in_base_a    <= s_tdata[7:0];
      in_base_b    <= s_tdata[15:8];
      in_bin_index <= s_tdata[19:16];
    end
  end

  bpsc_column_decode u_decode (
    .opcode (in_opcode),
    .base_a (in_base_a),
    .base_b (in_base_b),
    .info   (info)
  );

  bpsc_count_bank #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bank (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .opcode    (in_opcode),
    .info      (info),
    .bin_index (in_bin_index),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_result.cls;
  assign m_tdata  = {out_result.bin_value, out_result.transversion_total,
                     out_result.transition_total, out_result.mismatch_total,
                     out_result.match_total};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("Input stage is empty but the input is not ready.");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    advance && in_opcode == bpsc_pkg::OP_CLEAR |=> m_tvalid && m_tdata == '0)
    else $error("A clear beat did not report zero counts.");

  a_class_only_for_columns: assert property (@(posedge clk) disable iff (rst)
    advance && in_opcode != bpsc_pkg::OP_COLUMN |=> m_tuser == bpsc_pkg::CLASS_NONE)
    else $error("A non-column beat reported a column class.");

endmodule
